/* sv/wcs_pkg.sv */
`default_nettype none
package wcs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FIRST_COLUMN    = 3'd0;
  localparam logic [2:0] REG_WALL_COLUMNS    = 3'd1;
  localparam logic [2:0] REG_U_START_OVER_Z  = 3'd2;
  localparam logic [2:0] REG_U_END_OVER_Z    = 3'd3;
  localparam logic [2:0] REG_INV_DEPTH_START = 3'd4;
  localparam logic [2:0] REG_INV_DEPTH_END   = 3'd5;
  localparam logic [2:0] REG_V_EXTENT        = 3'd6;
  localparam logic [2:0] REG_TEXTURE_WIDTH   = 3'd7;

  localparam int ALPHA_FRAC   = 24;
  localparam int BLEND_W      = 57;
  localparam int MAX_TEX_W    = 4096;

  typedef struct packed {
    logic        [9:0]  column;
    logic signed [19:0] top_edge;
    logic signed [19:0] bottom_edge;
    logic        [9:0]  upper_limit;
    logic        [9:0]  lower_limit;
  } item_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [9:0]  span_top;
    logic [9:0]  span_bottom;
    logic [11:0] texture_u;
    logic [31:0] v_start;
    logic [31:0] v_step;
  } result_t;

endpackage
`default_nettype wire

/* sv/wcs_div.sv */
`default_nettype none
module wcs_div #(
  parameter int N = 32,
  parameter int M = 16
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] dividend,
  input  wire logic [M-1:0] divisor,
  output logic      [N-1:0] quotient,
  output logic      [M-1:0] remainder
);

  // One quotient bit per stage, restoring division, N stages deep.
  logic [N-1:0] nd [N];
  logic [N-1:0] q  [N];
  logic [M-1:0] r  [N];
  logic [M-1:0] dv [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0] nd_in;
    logic [N-1:0] q_in;
    logic [M-1:0] r_in;
    logic [M-1:0] dv_in;
    logic [M:0]   trial;
    logic [M:0]   diff;
    logic         take;

    if (k == 0) begin : g_first
      assign nd_in = dividend;
      assign q_in  = '0;
      assign r_in  = '0;
      assign dv_in = divisor;
    end else begin : g_next
      assign nd_in = nd[k-1];
      assign q_in  = q[k-1];
      assign r_in  = r[k-1];
      assign dv_in = dv[k-1];
    end

    assign trial = {r_in, nd_in[N-1]};
    assign take  = trial >= {1'b0, dv_in};
    assign diff  = trial - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      nd[k] <= nd_in << 1;
      q[k]  <= {q_in[N-2:0], take};
      r[k]  <= take ? diff[M-1:0] : trial[M-1:0];
      dv[k] <= dv_in;
    end
  end

  assign quotient  = q[N-1];
  assign remainder = r[N-1];

endmodule
`default_nettype wire

/* sv/wcs_dly.sv */
`default_nettype none
module wcs_dly #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] sr [D];

  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < D; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[D-1];

endmodule
`default_nettype wire

/* sv/wall_column_span_setup_top.sv */
`default_nettype none
// Wall column span setup. One column beat is taken every clock (busy is low
// except in reset) and its result appears on result, marked by done, after
// the input and clip registers, the three pipelined dividers in series on the
// texture column path (the blend weight division, the u/z over 1/z division
// and the modulo by the texture width, with the blend products between the
// first two) and the output register. The vertical step divider runs
// alongside and is delayed to match. Results cannot be held off, so they must
// be taken as they come. The user must write configuration registers only
// while no beat is in flight; the block itself does not enforce this.
module wall_column_span_setup_top
  import wcs_pkg::*;
#(
  parameter int EDGE_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW      = 11 + ALPHA_FRAC;
  localparam int SW      = 32 + EDGE_FRAC_BITS;
  localparam int T_NUM   = AW + 2;
  localparam int T_Q     = T_NUM + BLEND_W;
  localparam int T_U     = T_Q + BLEND_W;
  localparam int T_S     = SW + 2;
  localparam int LATENCY = T_U + 3;

  // Configuration registers.
  logic [9:0]  first_column;
  logic [10:0] wall_columns;
  logic [31:0] u_start_over_z;
  logic [31:0] u_end_over_z;
  logic [31:0] inv_depth_start;
  logic [31:0] inv_depth_end;
  logic [31:0] v_extent;
  logic [12:0] texture_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_column    <= '0;
      wall_columns    <= 11'd1;
      u_start_over_z  <= '0;
      u_end_over_z    <= '0;
      inv_depth_start <= '0;
      inv_depth_end   <= '0;
      v_extent        <= '0;
      texture_width   <= 13'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_COLUMN:    first_column    <= cfg_data[9:0];
        REG_WALL_COLUMNS:    wall_columns    <= cfg_data[10:0];
        REG_U_START_OVER_Z:  u_start_over_z  <= cfg_data;
        REG_U_END_OVER_Z:    u_end_over_z    <= cfg_data;
        REG_INV_DEPTH_START: inv_depth_start <= cfg_data;
        REG_INV_DEPTH_END:   inv_depth_end   <= cfg_data;
        REG_V_EXTENT:        v_extent        <= cfg_data;
        REG_TEXTURE_WIDTH:   texture_width   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [10:0] wall_w;
  logic [12:0] tex_w;
  assign wall_w = (wall_columns == '0) ? 11'd1 : wall_columns;
  assign tex_w  = (texture_width == '0) ? 13'd1 :
                  (texture_width > 13'(MAX_TEX_W)) ? 13'(MAX_TEX_W) : texture_width;

  assign busy = rst;

  // Input register.
  logic  v0;
  item_t in0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    in0 <= item;
  end

  // Clipping, edge gap and blend offset.
  logic signed [19:0] top_row;
  logic signed [19:0] bot_row;
  logic signed [20:0] upper_s;
  logic signed [20:0] lower_s;
  logic signed [20:0] top_s;
  logic signed [20:0] bot_s;
  logic signed [20:0] ctop;
  logic signed [20:0] cbot;
  logic signed [20:0] diff_s;
  logic signed [20:0] gap_s;
  logic [10:0]        d_raw;
  logic [10:0]        d_next;

  always_comb begin
    top_row = in0.top_edge >>> EDGE_FRAC_BITS;
    bot_row = in0.bottom_edge >>> EDGE_FRAC_BITS;
    upper_s = $signed({11'b0, in0.upper_limit});
    lower_s = $signed({11'b0, in0.lower_limit});
    top_s   = 21'(top_row);
    bot_s   = 21'(bot_row);
    diff_s  = '0;
    if (top_s < upper_s) begin
      ctop   = upper_s;
      diff_s = upper_s - top_s;
    end else if (top_s > lower_s) begin
      ctop = lower_s;
    end else begin
      ctop = top_s;
    end
    if (bot_s < ctop) begin
      cbot = ctop;
    end else if (bot_s > lower_s) begin
      cbot = lower_s;
    end else begin
      cbot = bot_s;
    end
    gap_s  = 21'(in0.bottom_edge) - 21'(in0.top_edge);
    d_raw  = (in0.column >= first_column) ? 11'(in0.column - first_column) : 11'd0;
    d_next = (d_raw > wall_w) ? wall_w : d_raw;
  end

  logic        v1;
  logic [9:0]  col1;
  logic [9:0]  top1;
  logic [9:0]  bot1;
  logic [19:0] diff1;
  logic [19:0] gap1;
  logic        gap_pos1;
  logic [10:0] d1;
  logic [10:0] w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    col1     <= in0.column;
    top1     <= ctop[9:0];
    bot1     <= cbot[9:0];
    diff1    <= diff_s[19:0];
    gap1     <= gap_s[19:0];
    gap_pos1 <= !gap_s[20] && (gap_s != '0);
    d1       <= d_next;
    w1       <= wall_w;
  end

  // Blend weight.
  logic [AW-1:0] alpha_q;
  logic [10:0]   alpha_rem;

  wcs_div #(.N(AW), .M(11)) u_alpha_div (
    .clk      (clk),
    .dividend ({d1, {ALPHA_FRAC{1'b0}}}),
    .divisor  (w1),
    .quotient (alpha_q),
    .remainder(alpha_rem)
  );

  logic [24:0] alpha;
  logic [24:0] inv_alpha;
  assign alpha     = alpha_q[24:0];
  assign inv_alpha = 25'(1 << ALPHA_FRAC) - alpha;

  logic [BLEND_W-1:0] pu0, pu1, pd0, pd1;
  logic [BLEND_W-1:0] num, den;

  always_ff @(posedge clk) begin
    pu0 <= BLEND_W'(u_start_over_z)  * BLEND_W'(inv_alpha);
    pu1 <= BLEND_W'(u_end_over_z)    * BLEND_W'(alpha);
    pd0 <= BLEND_W'(inv_depth_start) * BLEND_W'(inv_alpha);
    pd1 <= BLEND_W'(inv_depth_end)   * BLEND_W'(alpha);
    num <= pu0 + pu1;
    den <= pd0 + pd1;
  end

  // Perspective divide, then modulo texture width.
  logic [BLEND_W-1:0] ratio;
  logic [BLEND_W-1:0] ratio_rem;
  logic [BLEND_W-1:0] mod_q;
  logic [12:0]        u_rem;

  wcs_div #(.N(BLEND_W), .M(BLEND_W)) u_persp_div (
    .clk      (clk),
    .dividend (num),
    .divisor  (den),
    .quotient (ratio),
    .remainder(ratio_rem)
  );

  wcs_div #(.N(BLEND_W), .M(13)) u_mod_div (
    .clk      (clk),
    .dividend (ratio),
    .divisor  (tex_w),
    .quotient (mod_q),
    .remainder(u_rem)
  );

  logic den_zero_d;

  wcs_dly #(.W(1), .D(2 * BLEND_W)) u_den_dly (
    .clk(clk),
    .d  (den == '0),
    .q  (den_zero_d)
  );

  // Vertical step and start.
  logic [SW-1:0] step_q;
  logic [19:0]   step_rem;

  wcs_div #(.N(SW), .M(20)) u_step_div (
    .clk      (clk),
    .dividend (SW'(v_extent) << EDGE_FRAC_BITS),
    .divisor  (gap1),
    .quotient (step_q),
    .remainder(step_rem)
  );

  logic        gap_pos_d;
  logic [19:0] diff_d;

  wcs_dly #(.W(1), .D(SW)) u_gap_dly (
    .clk(clk),
    .d  (gap_pos1),
    .q  (gap_pos_d)
  );

  wcs_dly #(.W(20), .D(SW + 1)) u_diff_dly (
    .clk(clk),
    .d  (diff1),
    .q  (diff_d)
  );

  logic [31:0] step_r;
  logic [31:0] step_r2;
  logic [51:0] vprod;

  always_ff @(posedge clk) begin
    step_r  <= (!gap_pos_d || (|(step_q >> 32))) ? 32'hFFFF_FFFF : step_q[31:0];
    step_r2 <= step_r;
    vprod   <= 52'(diff_d) * 52'(step_r);
  end

  logic [31:0] vstart;
  assign vstart = (|vprod[51:32]) ? 32'hFFFF_FFFF : vprod[31:0];

  logic [63:0] vert_d;

  wcs_dly #(.W(64), .D(T_U - T_S)) u_vert_dly (
    .clk(clk),
    .d  ({vstart, step_r2}),
    .q  (vert_d)
  );

  logic [29:0] span_d;

  wcs_dly #(.W(30), .D(T_U)) u_span_dly (
    .clk(clk),
    .d  ({col1, top1, bot1}),
    .q  (span_d)
  );

  logic [T_U-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[T_U-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[T_U-1];
    end
    result.out_column  <= span_d[29:20];
    result.span_top    <= span_d[19:10];
    result.span_bottom <= span_d[9:0];
    result.texture_u   <= den_zero_d ? 12'd0 : u_rem[11:0];
    result.v_start     <= vert_d[63:32];
    result.v_step      <= vert_d[31:0];
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat did not complete after the pipeline latency");

  a_no_stall: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy raised outside reset");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe raised straight after reset");
`endif

endmodule
`default_nettype wire
